[rtl/mi3_pkg.sv]
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// No dependencies; used by every module of the block.
package mi3_pkg;

  localparam int NLANE = 9;
  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd33;

  typedef logic [3:0] idx_t;

  // Cofactor for adjugate entry i is  a[P]*a[Q] - a[R]*a[S], negated on odd lanes
  localparam idx_t COF_P [NLANE] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam idx_t COF_Q [NLANE] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam idx_t COF_R [NLANE] = '{4'd7, 4'd2, 4'd2, 4'd6, 4'd2, 4'd2, 4'd4, 4'd1, 4'd3};
  localparam idx_t COF_S [NLANE] = '{4'd5, 4'd7, 4'd4, 4'd5, 4'd6, 4'd3, 4'd6, 4'd6, 4'd1};
  localparam logic COF_NEG [NLANE] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // Control travelling alongside each item in the divider
  typedef struct packed {
    logic valid;
    logic singular;
  } mi3_ctl_t;

endpackage

[rtl/mi3_div_step.sv]
// One restoring-division stage: resolves one quotient bit in all nine lanes.
// Depends on mi3_pkg.
module mi3_div_step import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int DW = 99,
  parameter int RW = 163,
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mi3_ctl_t              ctl_in,
  input  logic [DW-1:0]         dabs_in,
  input  logic [RW-1:0]         rem_in [NLANE],
  input  logic [ELEM_WIDTH-1:0] q_in   [NLANE],
  input  logic                  neg_in [NLANE],
  input  logic                  ovf_in [NLANE],
  output mi3_ctl_t              ctl_out,
  output logic [DW-1:0]         dabs_out,
  output logic [RW-1:0]         rem_out [NLANE],
  output logic [ELEM_WIDTH-1:0] q_out   [NLANE],
  output logic                  neg_out [NLANE],
  output logic                  ovf_out [NLANE]
);

  logic [RW-1:0] dsh;

  assign dsh = RW'(dabs_in) << STEP;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  // compare and subtract per lane
  always_ff @(posedge clk) begin
    dabs_out <= dabs_in;
    for (int i = 0; i < NLANE; i++) begin
      neg_out[i] <= neg_in[i];
      ovf_out[i] <= ovf_in[i];
      if (rem_in[i] >= dsh) begin
        rem_out[i] <= rem_in[i] - dsh;
        q_out[i]   <= q_in[i] | (ELEM_WIDTH'(1) << STEP);
      end else begin
        rem_out[i] <= rem_in[i];
        q_out[i]   <= q_in[i];
      end
    end
  end

endmodule

[rtl/matrix_inverse_3x3_unit.sv]
// 3x3 signed fixed-point matrix inverse by adjugate over determinant.
// Depends on mi3_pkg and mi3_div_step.
//
//  channel   handshake             payload
//  input     start / busy          a00 .. a22
//  result    done (strobe)         inv00 .. inv22, singular, saturated
//  config    cfg_valid/cfg_ready   cfg_data (det_threshold)
//
// One item enters per cycle; busy is never raised.
// The pipeline holds front stages of products, determinant and magnitude
// work, one long-division stage per quotient bit, and a final stage of
// sign and clamp.
// Synchronous reset empties the pipeline and sets the threshold to 33.
// Results are not held: each is shown for one cycle on done.
module matrix_inverse_3x3_unit import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ELEM_WIDTH-1:0] a00,
  input  logic signed [ELEM_WIDTH-1:0] a01,
  input  logic signed [ELEM_WIDTH-1:0] a02,
  input  logic signed [ELEM_WIDTH-1:0] a10,
  input  logic signed [ELEM_WIDTH-1:0] a11,
  input  logic signed [ELEM_WIDTH-1:0] a12,
  input  logic signed [ELEM_WIDTH-1:0] a20,
  input  logic signed [ELEM_WIDTH-1:0] a21,
  input  logic signed [ELEM_WIDTH-1:0] a22,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [THR_W-1:0]             cfg_data,
  output logic                         done,
  output logic signed [ELEM_WIDTH-1:0] inv00,
  output logic signed [ELEM_WIDTH-1:0] inv01,
  output logic signed [ELEM_WIDTH-1:0] inv02,
  output logic signed [ELEM_WIDTH-1:0] inv10,
  output logic signed [ELEM_WIDTH-1:0] inv11,
  output logic signed [ELEM_WIDTH-1:0] inv12,
  output logic signed [ELEM_WIDTH-1:0] inv20,
  output logic signed [ELEM_WIDTH-1:0] inv21,
  output logic signed [ELEM_WIDTH-1:0] inv22,
  output logic                         singular,
  output logic                         saturated
);

  localparam int E  = ELEM_WIDTH;
  localparam int PW = 2 * E;          // one element product
  localparam int CW = 2 * E + 1;      // adjugate entry
  localparam int DW = 3 * E + 3;      // determinant
  localparam int RW = DW + E + 2 * FRAC_BITS;

  localparam logic [E-1:0] MAX_POS = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MAX_NEG = {1'b1, {(E-1){1'b0}}};

  logic signed [E-1:0] a_in [NLANE];
  logic [THR_W-1:0]    thr;

  assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // valid bits of the front stages
  logic v1, v2, v3, v4, v5;
  mi3_ctl_t ctl6;

  // stage 1: cofactor products
  logic signed [PW-1:0] p1 [NLANE];
  logic signed [PW-1:0] p2 [NLANE];
  logic signed [E-1:0]  r1 [3];

  // stage 2: adjugate
  logic signed [CW-1:0] adj2 [NLANE];
  logic signed [E-1:0]  r2 [3];

  // stage 3: partial products for the determinant
  logic signed [CW-1:0] adj3 [NLANE];
  logic signed [CW-1:0] pl3 [3];
  logic signed [CW-1:0] ph3 [3];

  // stage 4: determinant
  logic signed [CW-1:0] adj4 [NLANE];
  logic signed [DW-1:0] det4;

  // stage 5: magnitudes and result signs
  logic [CW-1:0] nabs5 [NLANE];
  logic          neg5  [NLANE];
  logic [DW-1:0] dabs5;
  logic          dzero5;

  // stage 6: scaled numerators, overflow and singular check
  logic [RW-1:0] rem6 [NLANE];
  logic [E-1:0]  q6   [NLANE];
  logic          neg6 [NLANE];
  logic          ovf6 [NLANE];
  logic [DW-1:0] dabs6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      ctl6 <= '0;
    end else begin
      v1             <= start && !busy;
      v2             <= v1;
      v3             <= v2;
      v4             <= v3;
      v5             <= v4;
      ctl6.valid     <= v5;
      ctl6.singular  <= dzero5 || (RW'(dabs5) < (RW'(thr) << (2 * FRAC_BITS)));
    end
  end

  logic signed [DW-1:0] det_sum;
  logic [RW-1:0]        num6 [NLANE];

  always_comb begin
    det_sum = '0;
    for (int k = 0; k < 3; k++) begin
      det_sum = det_sum + (DW'(ph3[k]) <<< E) + DW'(pl3[k]);
    end
    for (int i = 0; i < NLANE; i++) begin
      num6[i] = RW'(nabs5[i]) << (2 * FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      // stage 1
      p1[i] <= a_in[COF_P[i]] * a_in[COF_Q[i]];
      p2[i] <= a_in[COF_R[i]] * a_in[COF_S[i]];
      // stage 2
      adj2[i] <= COF_NEG[i] ? (CW'(p2[i]) - CW'(p1[i])) : (CW'(p1[i]) - CW'(p2[i]));
      // stage 3, 4
      adj3[i] <= adj2[i];
      adj4[i] <= adj3[i];
      // stage 5
      nabs5[i] <= adj4[i][CW-1] ? CW'(-adj4[i]) : CW'(adj4[i]);
      neg5[i]  <= adj4[i][CW-1] ^ det4[DW-1];
      // stage 6
      rem6[i] <= num6[i];
      q6[i]   <= '0;
      neg6[i] <= neg5[i];
      ovf6[i] <= num6[i] >= (RW'(dabs5) << E);
    end
    for (int k = 0; k < 3; k++) begin
      r1[k]  <= a_in[k];
      r2[k]  <= r1[k];
      pl3[k] <= r2[k] * $signed({1'b0, adj2[3*k][E-1:0]});
      ph3[k] <= r2[k] * $signed(adj2[3*k][CW-1:E]);
    end
    det4   <= det_sum;
    dabs5  <= det4[DW-1] ? DW'(-det4) : DW'(det4);
    dzero5 <= (det4 == '0);
    dabs6  <= dabs5;
  end

  // long division, most significant quotient bit first
  mi3_ctl_t      ctl_d  [E+1];
  logic [DW-1:0] dabs_d [E+1];
  logic [RW-1:0] rem_d  [E+1][NLANE];
  logic [E-1:0]  q_d    [E+1][NLANE];
  logic          neg_d  [E+1][NLANE];
  logic          ovf_d  [E+1][NLANE];

  assign ctl_d[0]  = ctl6;
  assign dabs_d[0] = dabs6;
  assign rem_d[0]  = rem6;
  assign q_d[0]    = q6;
  assign neg_d[0]  = neg6;
  assign ovf_d[0]  = ovf6;

  for (genvar s = 0; s < E; s++) begin : g_div
    mi3_div_step #(
      .ELEM_WIDTH(E),
      .DW(DW),
      .RW(RW),
      .STEP(E - 1 - s)
    ) u_step (
      .clk(clk),
      .rst(rst),
      .ctl_in(ctl_d[s]),
      .dabs_in(dabs_d[s]),
      .rem_in(rem_d[s]),
      .q_in(q_d[s]),
      .neg_in(neg_d[s]),
      .ovf_in(ovf_d[s]),
      .ctl_out(ctl_d[s+1]),
      .dabs_out(dabs_d[s+1]),
      .rem_out(rem_d[s+1]),
      .q_out(q_d[s+1]),
      .neg_out(neg_d[s+1]),
      .ovf_out(ovf_d[s+1])
    );
  end

  // sign, clamp and singular override
  logic [E-1:0] val_next [NLANE];
  logic         sat_next;
  logic [E-1:0] res [NLANE];

  always_comb begin
    sat_next = 1'b0;
    for (int i = 0; i < NLANE; i++) begin
      if (ctl_d[E].singular) begin
        val_next[i] = '0;
      end else if (!neg_d[E][i] && (ovf_d[E][i] || q_d[E][i] > MAX_POS)) begin
        val_next[i] = MAX_POS;
        sat_next    = 1'b1;
      end else if (neg_d[E][i] && (ovf_d[E][i] || q_d[E][i] > MAX_NEG)) begin
        val_next[i] = MAX_NEG;
        sat_next    = 1'b1;
      end else begin
        val_next[i] = neg_d[E][i] ? (~q_d[E][i] + 1'b1) : q_d[E][i];
      end
    end
    if (ctl_d[E].singular) begin
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d[E].valid;
    end
  end

  always_ff @(posedge clk) begin
    res       <= val_next;
    singular  <= ctl_d[E].singular;
    saturated <= sat_next;
  end

  assign inv00 = res[0];
  assign inv01 = res[1];
  assign inv02 = res[2];
  assign inv10 = res[3];
  assign inv11 = res[4];
  assign inv12 = res[5];
  assign inv20 = res[6];
  assign inv21 = res[7];
  assign inv22 = res[8];

endmodule

[rtl/mi3_checker.sv]
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
// Depends on mi3_pkg and matrix_inverse_3x3_unit.
module mi3_checker import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  done,
  input logic                  singular,
  input logic                  saturated,
  input logic [ELEM_WIDTH-1:0] inv00,
  input logic [ELEM_WIDTH-1:0] inv11,
  input logic [ELEM_WIDTH-1:0] inv22
);

  // the pipeline takes an item every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // a singular item reports no clamping
  a_sing_nosat: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> !saturated)
    else $error("singular item flagged saturated");

  // a singular item has a zero inverse, checked on the diagonal entries
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> (inv00 == '0) && (inv11 == '0) && (inv22 == '0))
    else $error("singular item with nonzero entries");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result straight after reset");

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .done(done),
  .singular(singular),
  .saturated(saturated),
  .inv00(inv00),
  .inv11(inv11),
  .inv22(inv22)
);

[bench/matrix_inverse_3x3_checker.sv]
// Checker for the 3x3 matrix inverse: watches the input, config and result
// channels, predicts each inverse and compares field by field.
// Depends on mi3_pkg.
`timescale 1ns / 100ps

module matrix_inverse_3x3_checker import mi3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [8:0][31:0]  mat,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [THR_W-1:0]  cfg_data,
  input  logic              done,
  input  logic [8:0][31:0]  inv,
  input  logic              singular,
  input  logic              saturated,
  output int                fails,
  output int                outstanding
);

  typedef struct packed {
    logic [8:0][31:0] inv;
    logic             singular;
    logic             saturated;
  } inverse_t;

  localparam logic signed [127:0] MAX_POS = 128'sd2147483647;
  localparam logic signed [127:0] MAX_NEG_MAG = 128'sd2147483648;

  inverse_t    pending_inverses[$];
  logic [THR_W-1:0] threshold;

  // Adjugate over determinant in 128-bit exact arithmetic
  function automatic inverse_t invert(logic [8:0][31:0] m, logic [THR_W-1:0] thr);
    logic signed [127:0] a[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det, dabs, num, q, lim, v;
    logic neg;
    inverse_t r;
    int i;
    r = '0;
    for (i = 0; i < 9; i++) a[i] = {{96{m[i][31]}}, m[i]};
    adj[0] = a[4] * a[8] - a[7] * a[5];
    adj[1] = -(a[1] * a[8] - a[2] * a[7]);
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = -(a[3] * a[8] - a[6] * a[5]);
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = -(a[0] * a[5] - a[2] * a[3]);
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = -(a[0] * a[7] - a[1] * a[6]);
    adj[8] = a[0] * a[4] - a[3] * a[1];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    dabs = det[127] ? -det : det;
    lim = {97'b0, thr} << 32;
    if (det == 0 || dabs < lim) begin
      r.singular = 1'b1;
      return r;
    end
    for (i = 0; i < 9; i++) begin
      neg = adj[i][127] ^ det[127];
      num = (adj[i][127] ? -adj[i] : adj[i]) << 32;
      q = num / dabs;
      if (!neg && q > MAX_POS) begin
        q = MAX_POS;
        r.saturated = 1'b1;
      end
      if (neg && q > MAX_NEG_MAG) begin
        q = MAX_NEG_MAG;
        r.saturated = 1'b1;
      end
      v = neg ? -q : q;
      r.inv[i] = v[31:0];
    end
    return r;
  endfunction

  assign outstanding = pending_inverses.size();

  // Track threshold, queue predictions, compare results
  always @(posedge clk) begin
    inverse_t want;
    int i;
    if (rst) begin
      threshold = THR_RESET;
      fails = 0;
      pending_inverses.delete();
    end else begin
      if (done) begin
        if (pending_inverses.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          want = pending_inverses.pop_front();
          for (i = 0; i < 9; i++)
            if (inv[i] !== want.inv[i]) begin
              $error("inv%0d%0d: expected %h, got %h", i / 3, i % 3, want.inv[i], inv[i]);
              fails++;
            end
          if (singular !== want.singular) begin
            $error("singular: expected %b, got %b", want.singular, singular);
            fails++;
          end
          if (saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, saturated);
            fails++;
          end
        end
      end
      if (start && !busy) pending_inverses.push_back(invert(mat, threshold));
      if (cfg_valid && cfg_ready) threshold = cfg_data;
    end
  end

endmodule

[bench/matrix_inverse_3x3_unit_tb.sv]
// Top of the matrix inverse testbench: clock, reset, stimulus and verdict.
// Depends on mi3_pkg, matrix_inverse_3x3_unit and matrix_inverse_3x3_checker.
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_tb import mi3_pkg::*;;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int DRAIN_CYCLES = 50;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, singular, saturated;
  logic [THR_W-1:0] cfg_data;
  logic [8:0][31:0] mat, inv;
  int fails, outstanding;

  matrix_inverse_3x3_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a00(mat[0]), .a01(mat[1]), .a02(mat[2]),
    .a10(mat[3]), .a11(mat[4]), .a12(mat[5]),
    .a20(mat[6]), .a21(mat[7]), .a22(mat[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done),
    .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]),
    .inv10(inv[3]), .inv11(inv[4]), .inv12(inv[5]),
    .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
    .singular(singular), .saturated(saturated)
  );

  matrix_inverse_3x3_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mat(mat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .inv(inv), .singular(singular), .saturated(saturated),
    .fails(fails), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Present one matrix; returns at the falling edge after it was taken
  task automatic put_matrix(input logic [8:0][31:0] m);
    logic was_busy;
    start <= 1'b1;
    mat <= m;
    do begin
      was_busy = busy;
      @(negedge clk);
    end while (was_busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Threshold writes only with the pipeline empty
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    logic was_ready;
    pause(1);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do begin
      was_ready = cfg_ready;
      @(negedge clk);
    end while (!was_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [8:0][31:0] diag(input logic [31:0] d0, d1, d2);
    logic [8:0][31:0] m;
    m = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  // Random matrix: mostly well-conditioned, some wild, some nearly singular
  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] m;
    int kind, i, sh;
    kind = $urandom_range(0, 9);
    sh = $urandom_range(8, 20);
    for (i = 0; i < 9; i++) begin
      if (kind < 5) m[i] = $signed($urandom_range(0, 2 ** sh)) - (2 ** (sh - 1));
      else if (kind < 7) m[i] = $urandom;
      else if (kind == 7) m[i] = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                       : 32'h7FFF_FFFF - $urandom_range(0, 3);
      else m[i] = $signed($urandom_range(0, 64)) - 32;
    end
    if (kind >= 5 && kind < 7 && $urandom_range(0, 1)) begin
      // duplicate a row, or nudge a copy so the determinant is tiny
      m[8:6] = m[2:0];
      if ($urandom_range(0, 1)) m[6] = m[6] + $urandom_range(1, 3);
    end
    return m;
  endfunction

  initial begin
    logic [8:0][31:0] m;
    logic [THR_W-1:0] thr;
    int n, burst, ph;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mat = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: identity, extremes, saturation, singular, threshold boundary
    put_matrix(diag(ONE, ONE, ONE));
    put_matrix(diag(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
    put_matrix('0);
    put_matrix({9{32'h7FFF_FFFF}});
    put_matrix({9{32'h8000_0000}});
    put_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    put_matrix(diag(32'd1, ONE, ONE));
    put_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    put_matrix(diag(32'd33, ONE, ONE));
    put_matrix(diag(32'd32, ONE, ONE));
    put_matrix(diag(-32'sd33, ONE, ONE));
    m = {32'd9, 32'd8, 32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
    put_matrix(m);
    m = {ONE, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'hFFFF_4000,
         32'h0002_0000, ONE, ONE, 32'h0004_0000};
    put_matrix(m);
    write_threshold('0);
    put_matrix('0);
    put_matrix(diag(32'd1, 32'd1, 32'd1));
    write_threshold({THR_W{1'b1}});
    put_matrix(diag(ONE, ONE, ONE));
    put_matrix({9{32'h8000_0000}} ^ diag(32'h8000_0000, 32'h0, 32'h0));
    put_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

    // Random phases at several thresholds, bursty sender
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: thr = THR_RESET;
        1: thr = '0;
        2: thr = THR_W'($urandom);
        3: thr = THR_W'($urandom_range(1, 4096));
        default: thr = {THR_W{1'b1}};
      endcase
      write_threshold(thr);
      n = 0;
      while (n < 186) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          put_matrix(rand_matrix());
          n++;
        end
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
        if (n > 90 && n < 110 && ph == 2)
          while (outstanding != 0) pause(1);
      end
    end

    pause(1);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
